[rtl/core/assert_macros.svh]
// Assertion macros shared by the framebuffer scan RTL.
// Simulation builds get concurrent assertions; synthesis builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checks a property on every rising clock edge outside reset.
`define LMFS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("lmfs assertion failed");
// Checks that the consequent holds in the cycle after the antecedent.
`define LMFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lmfs assertion failed");
`else
`define LMFS_ASSERT(lbl, clk, rst_n, prop)
`define LMFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[rtl/core/lmfs_pkg.sv]
`timescale 1ns / 1ps
// Types, constants and the row scan order of the LED framebuffer scan block.
// No dependencies; the front end, queue, back end and top level use it by scoped names.
package lmfs_pkg;

	localparam int ROWS_DEF          = 7;
	localparam int BYTES_PER_ROW_DEF = 35;
	localparam int SENT_BYTES_DEF    = 34;
	localparam int LINE_WIDTH_DEF    = 90;

	localparam int LAST_COLUMN = 271;
	localparam int SCAN_LEN    = 7;
	localparam int GLYPH_ROWS  = 7;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] BYTE_ONES = 8'hFF;

	localparam logic [2:0] MODE_CLEAR = 3'd0;
	localparam logic [2:0] MODE_PIXEL = 3'd1;
	localparam logic [2:0] MODE_BLIT  = 3'd2;
	localparam logic [2:0] MODE_CLIP  = 3'd3;
	localparam logic [2:0] MODE_SCAN  = 3'd4;

	typedef struct packed {
		logic [2:0]  mode;
		logic [8:0]  x_pos;
		logic [4:0]  y_pos;
		logic        pixel_on;
		logic [8:0]  bit_position;
		logic [55:0] glyph_rows;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [2:0] row_select;
		logic       last;
	} out_item_t;

	typedef enum logic [2:0] {
		OP_CLEAR,
		OP_PIXEL,
		OP_BLIT,
		OP_CLIP,
		OP_SCAN
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t     op;
		logic [2:0]  row;
		logic [5:0]  byte_idx;
		logic [2:0]  bit_sh;
		logic [55:0] glyph;
	} cmd_t;

	typedef struct packed {
		logic push;
		cmd_t cmd;
	} push_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_READ,
		BK_WRITE,
		BK_SCAN
	} back_state_t;

	// Panel rows are driven in an interleaved order to spread refresh flicker.
	function automatic logic [2:0] scan_row(input logic [2:0] step);
		case (step)
			3'd0: scan_row = 3'd5;
			3'd1: scan_row = 3'd0;
			3'd2: scan_row = 3'd3;
			3'd3: scan_row = 3'd1;
			3'd4: scan_row = 3'd6;
			3'd5: scan_row = 3'd4;
			3'd6: scan_row = 3'd2;
			default: scan_row = 3'd5;
		endcase
	endfunction

endpackage

[rtl/core/lmfs_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual port RAM: one write port, one read port with registered data.
// No dependencies.
module lmfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 245
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/core/lmfs_front.sv]
`timescale 1ns / 1ps
// Front end: accepts input transactions, decodes mode and coordinates into commands.
// Depends on lmfs_pkg.
module lmfs_front #(
	parameter int ROWS          = lmfs_pkg::ROWS_DEF,
	parameter int BYTES_PER_ROW = lmfs_pkg::BYTES_PER_ROW_DEF,
	parameter int LINE_WIDTH    = lmfs_pkg::LINE_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  lmfs_pkg::in_item_t item,
	input  logic               q_full,
	output logic               busy,
	output lmfs_pkg::push_t    push
);

	logic [4:0]  line_lut [32];
	logic [2:0]  row_lut [32];
	logic        accept;
	logic [14:0] col_sum;
	logic        col_ok;
	logic [8:0]  col;
	logic        byte_ok;
	logic [2:0]  step_q;

	// y is split into panel line and row with constant tables built at elaboration.
	for (genvar g = 0; g < 32; g++) begin : g_lut
		assign line_lut[g] = 5'(g / ROWS);
		assign row_lut[g]  = 3'(g % ROWS);
	end

	assign accept  = start & ~q_full;
	assign busy    = q_full;
	assign col_sum = 15'(item.x_pos) + 15'(line_lut[item.y_pos]) * 15'(LINE_WIDTH);
	assign col_ok  = col_sum <= 15'(lmfs_pkg::LAST_COLUMN);
	assign col     = 9'(lmfs_pkg::LAST_COLUMN) - col_sum[8:0];
	assign byte_ok = {1'b0, col[8:3]} < 7'(BYTES_PER_ROW);

	always_comb begin
		push.push         = 1'b0;
		push.cmd.op       = lmfs_pkg::OP_CLEAR;
		push.cmd.row      = row_lut[item.y_pos];
		push.cmd.byte_idx = item.bit_position[8:3];
		push.cmd.bit_sh   = item.bit_position[2:0];
		push.cmd.glyph    = item.glyph_rows;
		case (item.mode)
			lmfs_pkg::MODE_CLEAR: begin
				push.push = accept;
			end
			lmfs_pkg::MODE_PIXEL: begin
				// Pixels that are off or fall off the panel never reach the queue.
				push.push         = accept & item.pixel_on & col_ok & byte_ok;
				push.cmd.op       = lmfs_pkg::OP_PIXEL;
				push.cmd.byte_idx = col[8:3];
				push.cmd.bit_sh   = col[2:0];
			end
			lmfs_pkg::MODE_BLIT: begin
				push.push   = accept;
				push.cmd.op = lmfs_pkg::OP_BLIT;
			end
			lmfs_pkg::MODE_CLIP: begin
				push.push   = accept;
				push.cmd.op = lmfs_pkg::OP_CLIP;
			end
			lmfs_pkg::MODE_SCAN: begin
				push.push    = accept;
				push.cmd.op  = lmfs_pkg::OP_SCAN;
				push.cmd.row = lmfs_pkg::scan_row(step_q);
			end
			default: begin
				push.push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (accept && item.mode == lmfs_pkg::MODE_SCAN) begin
			step_q <= (step_q >= 3'(lmfs_pkg::SCAN_LEN - 1)) ? 3'd0 : step_q + 3'd1;
		end
	end

endmodule

[rtl/core/lmfs_cmd_fifo.sv]
`timescale 1ns / 1ps
// Short command queue between the front end and the back end.
// Depends on lmfs_pkg.
module lmfs_cmd_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  lmfs_pkg::push_t   push,
	input  logic              pop,
	output lmfs_pkg::cmd_t    head,
	output lmfs_pkg::q_stat_t q_stat
);

	localparam int Q     = lmfs_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (Q > 1) ? $clog2(Q) : 1;
	localparam int CNT_W = $clog2(Q + 1);

	lmfs_pkg::cmd_t entry_q [Q];
	logic [PTR_W-1:0] wp_q;
	logic [PTR_W-1:0] rp_q;
	logic [CNT_W-1:0] cnt_q;

	assign head         = entry_q[rp_q];
	assign q_stat.full  = cnt_q == CNT_W'(Q);
	assign q_stat.empty = cnt_q == '0;

	always_ff @(posedge clk) begin
		if (push.push) begin
			entry_q[wp_q] <= push.cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push.push) begin
				wp_q <= (wp_q == PTR_W'(Q - 1)) ? '0 : wp_q + PTR_W'(1);
			end
			if (pop) begin
				rp_q <= (rp_q == PTR_W'(Q - 1)) ? '0 : rp_q + PTR_W'(1);
			end
			if (push.push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push.push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

[rtl/core/lmfs_back.sv]
`timescale 1ns / 1ps
// Back end: runs queued commands against the frame store and streams row scans.
// Depends on lmfs_pkg and lmfs_ram.
module lmfs_back #(
	parameter int ROWS          = lmfs_pkg::ROWS_DEF,
	parameter int BYTES_PER_ROW = lmfs_pkg::BYTES_PER_ROW_DEF,
	parameter int SENT_BYTES    = lmfs_pkg::SENT_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lmfs_pkg::q_stat_t   q_stat,
	input  lmfs_pkg::cmd_t      head,
	output logic                pop,
	output logic                result_valid,
	output lmfs_pkg::out_item_t result
);

	localparam int DEPTH  = ROWS * BYTES_PER_ROW;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int ELEM_W = $clog2(ROWS + 1) + 1;
	localparam int CNT_W  = $clog2(SENT_BYTES + 1);

	lmfs_pkg::back_state_t state_q, state_d;
	lmfs_pkg::cmd_t        cur_q;
	logic [ELEM_W-1:0]     elem_q, elem_d, elem_last;
	logic [CNT_W-1:0]      cnt_q, cnt_d;
	logic [DEPTH-1:0]      vld_q;
	logic                  load_cur, clr_all, wr_en, issue;

	logic [2:0]        e_row;
	logic [6:0]        e_byte;
	logic [7:0]        g_byte;
	logic [15:0]       g_shift;
	logic [7:0]        clip_keep;
	logic [7:0]        and_m, or_v;
	logic              e_ok;
	logic [9:0]        e_addr_full;
	logic [ADDR_W-1:0] e_addr;
	logic [7:0]        old_byte, new_byte;

	logic [6:0]        s_byte;
	logic              s_ok;
	logic [9:0]        s_addr_full;
	logic [ADDR_W-1:0] s_addr;
	logic [ADDR_W-1:0] rd_addr;
	logic [7:0]        rdata;

	logic       valid_s1, last_s1, live_s1;
	logic [2:0] row_s1;
	logic       valid_s2;
	lmfs_pkg::out_item_t result_s2;

	// Blits and clips touch two bytes per row: element bit 0 picks the byte, the rest the row.
	assign e_row  = (cur_q.op == lmfs_pkg::OP_PIXEL) ? cur_q.row : 3'(elem_q[ELEM_W-1:1]);
	assign e_byte = 7'(cur_q.byte_idx) + 7'(elem_q[0]);
	assign g_byte = ({1'b0, e_row} >= 4'(lmfs_pkg::GLYPH_ROWS)) ? 8'h00
		: cur_q.glyph[{e_row, 3'b000} +: 8];
	assign g_shift   = {8'h00, g_byte} << cur_q.bit_sh;
	assign clip_keep = ~(lmfs_pkg::BYTE_ONES << cur_q.bit_sh);

	always_comb begin
		case (cur_q.op)
			lmfs_pkg::OP_PIXEL: begin
				and_m = lmfs_pkg::BYTE_ONES;
				or_v  = 8'h01 << cur_q.bit_sh;
			end
			lmfs_pkg::OP_BLIT: begin
				and_m = lmfs_pkg::BYTE_ONES;
				or_v  = elem_q[0] ? g_shift[15:8] : g_shift[7:0];
			end
			lmfs_pkg::OP_CLIP: begin
				and_m = elem_q[0] ? 8'h00 : clip_keep;
				or_v  = 8'h00;
			end
			default: begin
				and_m = lmfs_pkg::BYTE_ONES;
				or_v  = 8'h00;
			end
		endcase
	end

	assign e_ok        = ({1'b0, e_row} < 4'(ROWS)) && (e_byte < 7'(BYTES_PER_ROW));
	assign e_addr_full = 10'(e_row) * 10'(BYTES_PER_ROW) + 10'(e_byte);
	assign e_addr      = e_ok ? e_addr_full[ADDR_W-1:0] : '0;
	// An entry not written since the last clear reads as zero.
	assign old_byte    = vld_q[e_addr] ? rdata : 8'h00;
	assign new_byte    = (old_byte & and_m) | or_v;

	assign s_byte      = 7'(cnt_q);
	assign s_ok        = ({1'b0, cur_q.row} < 4'(ROWS)) && (s_byte < 7'(BYTES_PER_ROW));
	assign s_addr_full = 10'(cur_q.row) * 10'(BYTES_PER_ROW) + 10'(s_byte);
	assign s_addr      = s_ok ? s_addr_full[ADDR_W-1:0] : '0;
	assign rd_addr     = (state_q == lmfs_pkg::BK_SCAN) ? s_addr : e_addr;

	assign elem_last = (cur_q.op == lmfs_pkg::OP_PIXEL) ? '0 : ELEM_W'(2 * ROWS - 1);

	lmfs_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (wr_en),
		.waddr(e_addr),
		.wdata(new_byte),
		.raddr(rd_addr),
		.rdata(rdata)
	);

	always_comb begin
		state_d  = state_q;
		elem_d   = elem_q;
		cnt_d    = cnt_q;
		pop      = 1'b0;
		load_cur = 1'b0;
		clr_all  = 1'b0;
		wr_en    = 1'b0;
		issue    = 1'b0;
		case (state_q)
			lmfs_pkg::BK_IDLE: begin
				if (!q_stat.empty) begin
					pop      = 1'b1;
					load_cur = 1'b1;
					elem_d   = '0;
					cnt_d    = '0;
					case (head.op)
						lmfs_pkg::OP_CLEAR: clr_all = 1'b1;
						lmfs_pkg::OP_SCAN:  state_d = lmfs_pkg::BK_SCAN;
						default:            state_d = lmfs_pkg::BK_READ;
					endcase
				end
			end
			lmfs_pkg::BK_READ: begin
				state_d = lmfs_pkg::BK_WRITE;
			end
			lmfs_pkg::BK_WRITE: begin
				wr_en = e_ok;
				if (elem_q == elem_last) begin
					state_d = lmfs_pkg::BK_IDLE;
				end else begin
					elem_d  = elem_q + ELEM_W'(1);
					state_d = lmfs_pkg::BK_READ;
				end
			end
			lmfs_pkg::BK_SCAN: begin
				issue = 1'b1;
				if (cnt_q == CNT_W'(SENT_BYTES - 1)) begin
					state_d = lmfs_pkg::BK_IDLE;
				end else begin
					cnt_d = cnt_q + CNT_W'(1);
				end
			end
			default: begin
				state_d = lmfs_pkg::BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= lmfs_pkg::BK_IDLE;
			elem_q   <= '0;
			cnt_q    <= '0;
			vld_q    <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			state_q  <= state_d;
			elem_q   <= elem_d;
			cnt_q    <= cnt_d;
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
			if (clr_all) begin
				vld_q <= '0;
			end else if (wr_en) begin
				vld_q[e_addr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_cur) begin
			cur_q <= head;
		end
		last_s1              <= cnt_q == CNT_W'(SENT_BYTES - 1);
		row_s1               <= cur_q.row;
		live_s1              <= s_ok & vld_q[s_addr];
		result_s2.out_byte   <= live_s1 ? rdata : 8'h00;
		result_s2.row_select <= row_s1;
		result_s2.last       <= last_s1;
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

endmodule

[rtl/core/led_matrix_framebuffer_scan.sv]
`timescale 1ns / 1ps
// Top level of the LED matrix framebuffer and row scan controller.
// Depends on lmfs_pkg, lmfs_front, lmfs_cmd_fifo, lmfs_back and assert_macros.svh.
//
// A command transaction is taken on a rising edge with start high and busy low.
// Modes clear the store, set a pixel, OR in a glyph, clip at an end bit, or
// scan the next row of the panel's interleaved sequence.
// Commands pass through a two-entry queue; busy is high while the queue is full.
// In the back end a clear is done as the command is taken from the queue; a pixel
// touches one byte and a blit or clip two per row, and every touched byte costs a
// read and a write of the single frame store RAM port pair.
// A scan sends SENT_BYTES results (34 by default), one per cycle. With the back end
// idle, the first result passes the queue, the back end's scan state and the valid_s1
// and valid_s2 registers before it is on the ports; result_valid marks each one for a
// single cycle and result.last flags the final byte. Consecutive scans are separated
// by the idle state in which the next command is taken. The receiver cannot
// hold results off, so none is ever stalled.
// Reset clears the per-byte valid flags at once, so the store reads as all
// zero with no clearing pass; the scan sequence restarts at row five.
`include "assert_macros.svh"
module led_matrix_framebuffer_scan #(
	parameter int ROWS          = lmfs_pkg::ROWS_DEF,
	parameter int BYTES_PER_ROW = lmfs_pkg::BYTES_PER_ROW_DEF,
	parameter int SENT_BYTES    = lmfs_pkg::SENT_BYTES_DEF,
	parameter int LINE_WIDTH    = lmfs_pkg::LINE_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  lmfs_pkg::in_item_t  item,
	output logic                result_valid,
	output lmfs_pkg::out_item_t result
);

	lmfs_pkg::push_t   push;
	lmfs_pkg::q_stat_t q_stat;
	lmfs_pkg::cmd_t    head;
	logic              pop;

	lmfs_front #(
		.ROWS         (ROWS),
		.BYTES_PER_ROW(BYTES_PER_ROW),
		.LINE_WIDTH   (LINE_WIDTH)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.item  (item),
		.q_full(q_stat.full),
		.busy  (busy),
		.push  (push)
	);

	lmfs_cmd_fifo u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.pop   (pop),
		.head  (head),
		.q_stat(q_stat)
	);

	lmfs_back #(
		.ROWS         (ROWS),
		.BYTES_PER_ROW(BYTES_PER_ROW),
		.SENT_BYTES   (SENT_BYTES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_stat      (q_stat),
		.head        (head),
		.pop         (pop),
		.result_valid(result_valid),
		.result      (result)
	);

	// A scan streams its bytes without a gap and on one row.
	`LMFS_ASSERT_NEXT(a_scan_stream, clk, arst_n, result_valid && !result.last, result_valid)
	`LMFS_ASSERT_NEXT(a_scan_row_hold, clk, arst_n, result_valid && !result.last, result.row_select == $past(result.row_select))
	// At most one command enters the queue per cycle.
	`LMFS_ASSERT_NEXT(a_queue_fill, clk, arst_n, q_stat.empty, !q_stat.full)
	`LMFS_ASSERT(a_pop_nonempty, clk, arst_n, !(pop && q_stat.empty))

endmodule
